// File: src/rie_pkg.sv
// ----------------------------------------------------------------------------
// rie_pkg - shared types and constants of the RLP item encoder
// Widths, header offsets and the command word passed from front to back.
// ----------------------------------------------------------------------------
package rie_pkg;

	localparam int BYTE_W            = 8;
	localparam int LEN_W             = 32;
	// a 32-bit length never needs more than four length bytes
	localparam int LEN_BYTES         = LEN_W / BYTE_W;
	localparam int NLEN_W            = $clog2(LEN_BYTES + 1);
	localparam int SEL_W             = $clog2(LEN_BYTES);
	// header byte + length bytes + one payload byte
	localparam int MAX_RESULTS       = LEN_BYTES + 2;
	localparam int POS_W             = $clog2(MAX_RESULTS);
	localparam int MAX_LEN_BYTES_DEF = 4;

	localparam logic [LEN_W-1:0]  SHORT_LIMIT = 32'd55;
	localparam logic [BYTE_W-1:0] STR_SHORT   = 8'h80;
	localparam logic [BYTE_W-1:0] STR_LONG    = 8'hb7;
	localparam logic [BYTE_W-1:0] LIST_SHORT  = 8'hc0;
	localparam logic [BYTE_W-1:0] LIST_LONG   = 8'hf7;

	// one classified input item: which bytes to emit and the flags of its last byte
	typedef struct packed {
		logic                hdr_valid;
		logic [BYTE_W-1:0]   hdr_byte;
		logic [NLEN_W-1:0]   nlen;
		logic [LEN_W-1:0]    len;
		logic                data_valid;
		logic [BYTE_W-1:0]   data_byte;
		logic                done;
		logic                orphan;
	} cmd_t;

	typedef struct packed {
		logic head_valid;
		logic full;
	} q_status_t;

endpackage

// File: src/rie_front.sv
// ----------------------------------------------------------------------------
// rie_front - item classifier
// Saturates the length, builds the header and tracks the bytes still owed.
// ----------------------------------------------------------------------------
module rie_front #(
	parameter int MAX_LEN_BYTES = rie_pkg::MAX_LEN_BYTES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               accept,
	input  logic                               start_req,
	input  logic                               is_list,
	input  logic [rie_pkg::LEN_W-1:0]          payload_length,
	input  logic [rie_pkg::BYTE_W-1:0]         data_byte,
	output rie_pkg::cmd_t                      cmd
);
	import rie_pkg::*;

	localparam logic [LEN_W-1:0] LEN_CAP = (MAX_LEN_BYTES >= LEN_BYTES) ? {LEN_W{1'b1}} :
		LEN_W'((64'd1 << (BYTE_W * MAX_LEN_BYTES)) - 64'd1);

	logic [LEN_W-1:0]  rem_q;
	logic [LEN_W-1:0]  len_sat;
	logic [NLEN_W-1:0] n_bytes;
	logic [BYTE_W-1:0] off_short;
	logic [BYTE_W-1:0] off_long;
	logic              bare;
	logic              len_zero;

	assign len_sat   = (payload_length > LEN_CAP) ? LEN_CAP : payload_length;
	assign off_short = is_list ? LIST_SHORT : STR_SHORT;
	assign off_long  = is_list ? LIST_LONG : STR_LONG;
	assign len_zero  = (len_sat == '0);
	assign bare      = !is_list && (len_sat == LEN_W'(1)) && !data_byte[BYTE_W-1];

	// count of significant length bytes
	always_comb begin
		priority if (len_sat[31:24] != '0) begin
			n_bytes = NLEN_W'(4);
		end else if (len_sat[23:16] != '0) begin
			n_bytes = NLEN_W'(3);
		end else if (len_sat[15:8] != '0) begin
			n_bytes = NLEN_W'(2);
		end else begin
			n_bytes = NLEN_W'(1);
		end
	end

	always_comb begin
		cmd            = '0;
		cmd.len        = len_sat;
		cmd.data_byte  = data_byte;
		if (start_req) begin
			cmd.hdr_valid  = !bare;
			cmd.data_valid = !len_zero;
			cmd.done       = len_zero || (len_sat == LEN_W'(1));
			if (len_zero) begin
				cmd.hdr_byte = off_short;
			end else if (len_sat <= SHORT_LIMIT) begin
				cmd.hdr_byte = off_short + len_sat[BYTE_W-1:0];
			end else begin
				cmd.hdr_byte = off_long + BYTE_W'(n_bytes);
				cmd.nlen     = n_bytes;
			end
		end else begin
			cmd.data_valid = 1'b1;
			cmd.orphan     = (rem_q == '0);
			cmd.done       = (rem_q == LEN_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (accept) begin
			if (start_req) begin
				rem_q <= len_zero ? '0 : len_sat - LEN_W'(1);
			end else if (rem_q != '0) begin
				rem_q <= rem_q - LEN_W'(1);
			end
		end
	end

endmodule

// File: src/rie_queue.sv
// ----------------------------------------------------------------------------
// rie_queue - two-entry command queue
// Decouples the classifier from the byte sequencer.
// ----------------------------------------------------------------------------
module rie_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  rie_pkg::cmd_t      push_cmd,
	input  logic               pop,
	output rie_pkg::cmd_t      head,
	output rie_pkg::q_status_t status
);
	import rie_pkg::*;

	cmd_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign head              = mem_q[rd_ptr_q];
	assign status.head_valid = (cnt_q != 2'd0);
	assign status.full       = (cnt_q == 2'd2);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: src/rie_back.sv
// ----------------------------------------------------------------------------
// rie_back - byte sequencer
// Walks a command byte by byte into the output register.
// ----------------------------------------------------------------------------
module rie_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rie_pkg::cmd_t               head,
	input  logic                        head_valid,
	output logic                        pop,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [rie_pkg::BYTE_W-1:0]  m_tdata,
	output logic                        m_tlast,
	output logic [1:0]                  m_tuser
);
	import rie_pkg::*;

	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  count;
	logic [POS_W-1:0]  idx;
	logic [SEL_W-1:0]  sel;
	logic [BYTE_W-1:0] cur_byte;
	logic              at_last;
	logic              adv;
	logic              valid_q;
	logic [BYTE_W-1:0] byte_q;
	logic              last_q;
	logic              done_q;
	logic              orphan_q;

	assign count   = POS_W'(head.hdr_valid) + POS_W'(head.nlen) + POS_W'(head.data_valid);
	assign at_last = (pos_q == count - POS_W'(1));
	assign adv     = head_valid && (!valid_q || m_tready);
	assign pop     = adv && at_last;
	assign idx     = pos_q - POS_W'(head.hdr_valid);
	// length bytes go out most significant first
	assign sel     = SEL_W'(POS_W'(head.nlen) - POS_W'(1) - idx);

	always_comb begin
		if (head.hdr_valid && (pos_q == '0)) begin
			cur_byte = head.hdr_byte;
		end else if (idx < POS_W'(head.nlen)) begin
			cur_byte = head.len[sel*BYTE_W +: BYTE_W];
		end else begin
			cur_byte = head.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (adv) begin
				pos_q   <= at_last ? '0 : pos_q + POS_W'(1);
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			byte_q   <= cur_byte;
			last_q   <= at_last;
			done_q   <= at_last && head.done;
			orphan_q <= at_last && head.orphan;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = byte_q;
	assign m_tlast  = last_q;
	assign m_tuser  = {orphan_q, done_q};

endmodule

// File: src/rlp_item_encoder_core.sv
// ----------------------------------------------------------------------------
// rlp_item_encoder_core - streaming RLP framer
// One payload byte in per item, RLP-framed bytes out.
// ----------------------------------------------------------------------------
// A start item (s_tuser[0]) opens a payload of the given length and emits its
// header followed by the byte it carries; later items emit one payload byte
// each. Output rate is one byte per cycle while m_tready is high, set by the
// single output register of the byte sequencer. Items causing one byte (any
// non-start item, a bare byte or a zero-length header) therefore stream at
// one per cycle while m_tready is high. A start item causes two bytes for a
// short header, three to six for a long one (header, one to four length
// bytes, the byte). A two-entry queue sits between classifier and sequencer,
// so input keeps flowing while a header expands or the output stalls, and is
// held off only once the queue is full. With the sequencer idle, the command
// of an accepted item is written to a queue entry, and its first output byte
// then to the output register before it is presented. Lengths wider than
// MAX_LEN_BYTES length bytes saturate.
// ----------------------------------------------------------------------------
module rlp_item_encoder_core #(
	parameter int MAX_LEN_BYTES = rie_pkg::MAX_LEN_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // [31:0] payload_length, [39:32] data_byte
	input  logic [1:0]  s_tuser,  // [0] start_req, [1] is_list
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // [7:0] out_byte
	output logic        m_tlast,  // last_of_run
	output logic [1:0]  m_tuser   // [0] payload_done, [1] orphan_error
);
	import rie_pkg::*;

	cmd_t      front_cmd;
	cmd_t      head;
	q_status_t q_status;
	logic      accept;
	logic      pop;

	// the queue has room for this item
	assign s_tready = !q_status.full;
	assign accept   = s_tvalid && s_tready;

	rie_front #(
		.MAX_LEN_BYTES (MAX_LEN_BYTES)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.start_req      (s_tuser[0]),
		.is_list        (s_tuser[1]),
		.payload_length (s_tdata[LEN_W-1:0]),
		.data_byte      (s_tdata[LEN_W +: BYTE_W]),
		.cmd            (front_cmd)
	);

	rie_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_cmd (front_cmd),
		.pop      (pop),
		.head     (head),
		.status   (q_status)
	);

	rie_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (q_status.head_valid),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

	// completion and orphan flags only ever mark the final byte of an item
	a_flags_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[0] || m_tuser[1]) |-> m_tlast)
		else $error("payload flag on a byte that is not the last of its item");

	// an orphan byte never completes a payload
	a_orphan_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("orphan byte flagged as payload completion");

	// a command leaves the queue only when one was there
	a_pop_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_status.head_valid)
		else $error("queue popped while empty");

	// with the queue full the input side must be held off
	a_full_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		q_status.full |-> !accept)
		else $error("item accepted into a full queue");

endmodule
